FILE: src/bfa_pkg.sv
// Shared widths, defaults and status codes of the best-fit allocator.
`timescale 1ns / 1ps
`default_nettype none

package bfa_pkg;

  localparam int DATA_W          = 16;  // size, start and register width
  localparam int CNT_OUT_W       = 6;   // width of the reported extent count
  localparam int MAX_EXTENTS_DEF = 32;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: src/bfa_req_if.sv
// Request channel of the allocator: valid/ready handshake with one request word.
`timescale 1ns / 1ps
`default_nettype none

interface bfa_req_if
  import bfa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              action;
  logic [DATA_W-1:0] req_size;
  logic [DATA_W-1:0] block_start;

  modport source (output valid, output action, output req_size, output block_start,
                  input ready);
  modport sink   (input valid, input action, input req_size, input block_start,
                  output ready);
endinterface

`default_nettype wire

FILE: src/bfa_rsp_if.sv
// Response channel of the allocator: valid/ready handshake with one result word.
`timescale 1ns / 1ps
`default_nettype none

interface bfa_rsp_if
  import bfa_pkg::*;
;
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [DATA_W-1:0]    granted_start;
  logic [CNT_OUT_W-1:0] free_extents;

  modport source (output valid, output status, output granted_start, output free_extents,
                  input ready);
  modport sink   (input valid, input status, input granted_start, input free_extents,
                  output ready);
endinterface

`default_nettype wire

FILE: src/bfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/best_fit_allocator_unit.sv
// Best-fit allocator: free-extent table in RAM, walked by a small sequencer.
//
// Usage: requests arrive on req (action 0 allocate, 1 free, with req_size and
// block_start); one result word per request leaves on rsp (status, granted
// start, number of free extents held afterwards). Both channels move a word
// when valid and ready are high at a rising clock edge. cfg_we_i writes the
// memory size and re-initializes the free table; write it only while idle.
// Sequence: each request walks the address-ordered extent table through the
// single RAM read port, one entry a cycle, takes a decision step, then,
// when an extent is removed or inserted, moves the table tail one entry a
// cycle, and posts the result in a final step; req is not ready meanwhile.
// After reset and after every size write the block writes the first table
// entry before it is ready. A stalled receiver holds the result in the
// output register; the next request is still accepted and waits only at its
// own result cycle.
`timescale 1ns / 1ps
`default_nettype none

module best_fit_allocator_unit
  import bfa_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [DATA_W-1:0] cfg_wdata_i,
  bfa_req_if.sink                req,
  bfa_rsp_if.source              rsp
);

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = 2 * DATA_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] len;
  } extent_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    FIN_NONE = 2'd0,
    FIN_DEC  = 2'd1,
    FIN_INS  = 2'd2
  } fin_e;

  state_e              state_q, state_d;
  logic                pend_q, pend_d;
  logic [DATA_W-1:0]   total_q, total_d;
  logic [CW-1:0]       count_q, count_d;
  logic                act_q, act_d;
  logic [DATA_W-1:0]   size_q, size_d;
  logic [DATA_W-1:0]   bstart_q, bstart_d;
  logic [CW-1:0]       rd_q, rd_d;
  logic                rv_q, rv_d;
  logic [IW-1:0]       dat_q, dat_d;
  logic [CW-1:0]       n_q, n_d;
  logic                up_q, up_d;
  logic                found_q, found_d;
  logic [IW-1:0]       best_idx_q, best_idx_d;
  logic [DATA_W-1:0]   best_len_q, best_len_d;
  logic [DATA_W-1:0]   best_start_q, best_start_d;
  logic                ovl_q, ovl_d;
  logic [CW-1:0]       p_q, p_d;
  logic [DATA_W-1:0]   lft_s_q, lft_s_d;
  logic [DATA_W-1:0]   lft_len_q, lft_len_d;
  logic [DATA_W:0]     lft_end_q, lft_end_d;
  logic                have_r_q, have_r_d;
  logic [DATA_W-1:0]   rgt_s_q, rgt_s_d;
  logic [DATA_W-1:0]   rgt_len_q, rgt_len_d;
  fin_e                fin_q, fin_d;
  status_e             res_st_q, res_st_d;
  logic [DATA_W-1:0]   res_grant_q, res_grant_d;
  logic                ov_q, ov_d;
  status_e             o_st_q, o_st_d;
  logic [DATA_W-1:0]   o_grant_q, o_grant_d;
  logic [CNT_OUT_W-1:0] o_cnt_q, o_cnt_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  extent_t       ram_wdata;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  extent_t       rd_ext;
  logic [DATA_W:0] rd_end;
  logic [DATA_W:0] req_end;
  logic          lft_hit, rgt_hit;
  logic [CW-1:0] cnt_new;

  bfa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EXTENTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_ext  = ram_rdata;
  assign rd_end  = {1'b0, rd_ext.start} + {1'b0, rd_ext.len};
  assign req_end = {1'b0, bstart_q} + {1'b0, size_q};
  assign lft_hit = (p_q != '0) && (lft_end_q == {1'b0, bstart_q});
  assign rgt_hit = have_r_q && (req_end == {1'b0, rgt_s_q});

  assign req.ready         = (state_q == S_IDLE) && !pend_q;
  assign rsp.valid         = ov_q;
  assign rsp.status        = o_st_q;
  assign rsp.granted_start = o_grant_q;
  assign rsp.free_extents  = o_cnt_q;

  always_comb begin
    state_d      = state_q;
    pend_d       = pend_q;
    total_d      = total_q;
    count_d      = count_q;
    act_d        = act_q;
    size_d       = size_q;
    bstart_d     = bstart_q;
    rd_d         = rd_q;
    rv_d         = rv_q;
    dat_d        = dat_q;
    n_d          = n_q;
    up_d         = up_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_len_d   = best_len_q;
    best_start_d = best_start_q;
    ovl_d        = ovl_q;
    p_d          = p_q;
    lft_s_d      = lft_s_q;
    lft_len_d    = lft_len_q;
    lft_end_d    = lft_end_q;
    have_r_d     = have_r_q;
    rgt_s_d      = rgt_s_q;
    rgt_len_d    = rgt_len_q;
    fin_d        = fin_q;
    res_st_d     = res_st_q;
    res_grant_d  = res_grant_q;
    ov_d         = ov_q;
    o_st_d       = o_st_q;
    o_grant_d    = o_grant_q;
    o_cnt_d      = o_cnt_q;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = rd_q[IW-1:0];
    cnt_new      = count_q;

    // drop the result word once taken
    if (ov_q && rsp.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (pend_q) begin
          // table holds one extent covering the whole memory
          ram_we          = 1'b1;
          ram_waddr       = '0;
          ram_wdata.start = '0;
          ram_wdata.len   = total_q;
          pend_d          = 1'b0;
        end else if (req.valid) begin
          act_d    = req.action;
          size_d   = req.req_size;
          bstart_d = req.block_start;
          rd_d     = '0;
          rv_d     = 1'b0;
          found_d  = 1'b0;
          ovl_d    = 1'b0;
          p_d      = '0;
          have_r_d = 1'b0;
          state_d  = S_SCAN;
        end
      end

      S_SCAN: begin
        if (rd_q < count_q) begin
          rd_d  = rd_q + CW'(1);
          rv_d  = 1'b1;
          dat_d = rd_q[IW-1:0];
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          if (!act_q) begin
            if ((rd_ext.len >= size_q) && (!found_q || (rd_ext.len < best_len_q))) begin
              found_d      = 1'b1;
              best_idx_d   = dat_q;
              best_len_d   = rd_ext.len;
              best_start_d = rd_ext.start;
            end
          end else begin
            if (({1'b0, bstart_q} < rd_end) && ({1'b0, rd_ext.start} < req_end)) begin
              ovl_d = 1'b1;
            end
            if (rd_ext.start <= bstart_q) begin
              p_d       = p_q + CW'(1);
              lft_s_d   = rd_ext.start;
              lft_len_d = rd_ext.len;
              lft_end_d = rd_end;
            end else if (!have_r_q) begin
              have_r_d  = 1'b1;
              rgt_s_d   = rd_ext.start;
              rgt_len_d = rd_ext.len;
            end
          end
        end
        if ((rd_q >= count_q) && !rv_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d     = S_FIN;
        fin_d       = FIN_NONE;
        res_grant_d = '0;
        res_st_d    = ST_OK;
        if (!act_q) begin
          if (size_q == '0) begin
            res_st_d = ST_BAD;
          end else if (!found_q) begin
            res_st_d = ST_NOFIT;
          end else begin
            res_grant_d = best_start_q;
            if (best_len_q == size_q) begin
              // exact fit: close the gap above the extent
              rd_d    = CW'(best_idx_q) + CW'(1);
              n_d     = count_q - CW'(best_idx_q) - CW'(1);
              up_d    = 1'b1;
              fin_d   = FIN_DEC;
              state_d = S_SHIFT;
            end else begin
              ram_we          = 1'b1;
              ram_waddr       = best_idx_q;
              ram_wdata.start = best_start_q + size_q;
              ram_wdata.len   = best_len_q - size_q;
            end
          end
        end else begin
          if ((size_q == '0) || (req_end > {1'b0, total_q}) || ovl_q) begin
            res_st_d = ST_BAD;
          end else if (lft_hit && rgt_hit) begin
            ram_we          = 1'b1;
            ram_waddr       = IW'(p_q - CW'(1));
            ram_wdata.start = lft_s_q;
            ram_wdata.len   = lft_len_q + size_q + rgt_len_q;
            rd_d            = p_q + CW'(1);
            n_d             = count_q - p_q - CW'(1);
            up_d            = 1'b1;
            fin_d           = FIN_DEC;
            state_d         = S_SHIFT;
          end else if (lft_hit) begin
            ram_we          = 1'b1;
            ram_waddr       = IW'(p_q - CW'(1));
            ram_wdata.start = lft_s_q;
            ram_wdata.len   = lft_len_q + size_q;
          end else if (rgt_hit) begin
            ram_we          = 1'b1;
            ram_waddr       = p_q[IW-1:0];
            ram_wdata.start = bstart_q;
            ram_wdata.len   = rgt_len_q + size_q;
          end else if (count_q >= CNT_MAX) begin
            res_st_d = ST_FULL;
          end else begin
            // open a slot at the insert point, moving the tail up by one
            rd_d    = count_q - CW'(1);
            n_d     = count_q - p_q;
            up_d    = 1'b0;
            fin_d   = FIN_INS;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        if (n_q != '0) begin
          rd_d  = up_q ? (rd_q + CW'(1)) : (rd_q - CW'(1));
          n_d   = n_q - CW'(1);
          rv_d  = 1'b1;
          dat_d = rd_q[IW-1:0];
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          ram_we    = 1'b1;
          ram_waddr = up_q ? (dat_q - IW'(1)) : (dat_q + IW'(1));
          ram_wdata = rd_ext;
        end
        if ((n_q == '0) && !rv_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        case (fin_q)
          FIN_DEC: cnt_new = count_q - CW'(1);
          FIN_INS: cnt_new = count_q + CW'(1);
          default: cnt_new = count_q;
        endcase
        // hold until the output register is free
        if (!ov_q || rsp.ready) begin
          count_d   = cnt_new;
          ov_d      = 1'b1;
          o_st_d    = res_st_q;
          o_grant_d = res_grant_q;
          o_cnt_d   = CNT_OUT_W'(cnt_new);
          if (fin_q == FIN_INS) begin
            ram_we          = 1'b1;
            ram_waddr       = p_q[IW-1:0];
            ram_wdata.start = bstart_q;
            ram_wdata.len   = size_q;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      total_d = cfg_wdata_i;
      pend_d  = 1'b1;
      count_d = CW'(cfg_wdata_i != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b1;
      total_q <= '1;
      count_q <= CW'(1);
      rv_q    <= 1'b0;
      n_q     <= '0;
      up_q    <= 1'b0;
      fin_q   <= FIN_NONE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      total_q <= total_d;
      count_q <= count_d;
      rv_q    <= rv_d;
      n_q     <= n_d;
      up_q    <= up_d;
      fin_q   <= fin_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    size_q       <= size_d;
    bstart_q     <= bstart_d;
    rd_q         <= rd_d;
    dat_q        <= dat_d;
    found_q      <= found_d;
    best_idx_q   <= best_idx_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    ovl_q        <= ovl_d;
    p_q          <= p_d;
    lft_s_q      <= lft_s_d;
    lft_len_q    <= lft_len_d;
    lft_end_q    <= lft_end_d;
    have_r_q     <= have_r_d;
    rgt_s_q      <= rgt_s_d;
    rgt_len_q    <= rgt_len_d;
    res_st_q     <= res_st_d;
    res_grant_q  <= res_grant_d;
    o_st_q       <= o_st_d;
    o_grant_q    <= o_grant_d;
    o_cnt_q      <= o_cnt_d;
  end

endmodule

`default_nettype wire

FILE: dv/best_fit_allocator_unit_test.sv
// Self-checking bench for the best-fit allocator: random and directed requests, predicted results.
`timescale 1ns / 1ps

module best_fit_allocator_unit_test;
  import bfa_pkg::*;

  localparam int TABLE_DEPTH = MAX_EXTENTS_DEF;

  typedef struct {
    status_e              status;
    logic [DATA_W-1:0]    granted;
    logic [CNT_OUT_W-1:0] extents;
  } outcome_t;

  typedef struct {
    bit [DATA_W-1:0] base;
    bit [DATA_W-1:0] len;
  } block_t;

  class alloc_scoreboard;
    bit [DATA_W-1:0] mem_size;
    bit [DATA_W-1:0] ext_base [TABLE_DEPTH];
    bit [DATA_W-1:0] ext_len  [TABLE_DEPTH];
    int              ext_cnt;
    outcome_t        outcome_q [$];
    int              fails;

    function new();
      fails = 0;
      reload_table(16'hFFFF);
    endfunction

    function void reload_table(bit [DATA_W-1:0] size);
      mem_size = size;
      foreach (ext_base[i]) begin
        ext_base[i] = '0;
        ext_len[i]  = '0;
      end
      ext_cnt = 0;
      if (size != 0) begin
        ext_len[0] = size;
        ext_cnt    = 1;
      end
    endfunction

    function void drop_extent(int p);
      for (int i = p; i + 1 < ext_cnt; i++) begin
        ext_base[i] = ext_base[i+1];
        ext_len[i]  = ext_len[i+1];
      end
      ext_cnt--;
      ext_base[ext_cnt] = '0;
      ext_len[ext_cnt]  = '0;
    endfunction

    // Smallest extent that fits; the strict compare keeps the lowest address on a tie.
    function status_e carve_block(bit [DATA_W-1:0] size, output bit [DATA_W-1:0] grant);
      int pick;
      pick  = -1;
      grant = '0;
      if (size == 0) return ST_BAD;
      for (int i = 0; i < ext_cnt; i++) begin
        if (ext_len[i] >= size && (pick < 0 || ext_len[i] < ext_len[pick])) pick = i;
      end
      if (pick < 0) return ST_NOFIT;
      grant = ext_base[pick];
      if (ext_len[pick] == size) begin
        drop_extent(pick);
      end else begin
        ext_len[pick]  -= size;
        ext_base[pick] += size;
      end
      return ST_OK;
    endfunction

    function status_e return_block(bit [DATA_W-1:0] start, bit [DATA_W-1:0] size);
      bit [DATA_W:0] stop;
      bit [DATA_W:0] tail;
      int            p;
      bit            joins_lo;
      bit            joins_hi;
      stop = start + size;
      if (size == 0 || stop > mem_size) return ST_BAD;
      for (int i = 0; i < ext_cnt; i++) begin
        tail = ext_base[i] + ext_len[i];
        if (start < tail && ext_base[i] < stop) return ST_BAD;
      end
      p = 0;
      while (p < ext_cnt && ext_base[p] <= start) p++;
      joins_lo = 1'b0;
      joins_hi = 1'b0;
      if (p > 0) begin
        tail     = ext_base[p-1] + ext_len[p-1];
        joins_lo = (tail == start);
      end
      if (p < ext_cnt) joins_hi = (stop == ext_base[p]);
      if (joins_lo && joins_hi) begin
        ext_len[p-1] += size + ext_len[p];
        drop_extent(p);
      end else if (joins_lo) begin
        ext_len[p-1] += size;
      end else if (joins_hi) begin
        ext_base[p] = start;
        ext_len[p] += size;
      end else begin
        if (ext_cnt >= TABLE_DEPTH) return ST_FULL;
        for (int i = ext_cnt; i > p; i--) begin
          ext_base[i] = ext_base[i-1];
          ext_len[i]  = ext_len[i-1];
        end
        ext_base[p] = start;
        ext_len[p]  = size;
        ext_cnt++;
      end
      return ST_OK;
    endfunction

    function void note_request(bit act, bit [DATA_W-1:0] size, bit [DATA_W-1:0] start,
                               output status_e st, output bit [DATA_W-1:0] grant);
      outcome_t o;
      grant = '0;
      if (!act) st = carve_block(size, grant);
      else      st = return_block(start, size);
      o.status  = st;
      o.granted = grant;
      o.extents = CNT_OUT_W'(ext_cnt);
      outcome_q.push_back(o);
    endfunction

    function int pending();
      return outcome_q.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_result(logic [1:0] st, logic [DATA_W-1:0] grant, logic [CNT_OUT_W-1:0] cnt);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        report($sformatf("result word with no request waiting (status %0d)", st));
        return;
      end
      want = outcome_q.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (grant !== want.granted)
        report($sformatf("granted_start %0d, expected %0d", grant, want.granted));
      if (cnt !== want.extents)
        report($sformatf("free_extents %0d, expected %0d", cnt, want.extents));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [DATA_W-1:0] cfg_wdata_i;

  bfa_req_if req_ch ();
  bfa_rsp_if rsp_ch ();

  best_fit_allocator_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .rsp         (rsp_ch)
  );

  alloc_scoreboard sb = new();
  block_t          live_q [$];
  int              burst_left;
  bit              steady;
  int              hold_left;
  bit              hold_val;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("FAIL best_fit_allocator_unit");
    $finish;
  end

  // Receiver: ready runs in stretches, long open ones and short stalls.
  always @(posedge clk_i) begin
    if (hold_left == 0) begin
      hold_val  = ($urandom_range(0, 3) != 0);
      hold_left = hold_val ? $urandom_range(1, 40) : $urandom_range(1, 8);
    end else begin
      hold_left--;
    end
    rsp_ch.ready <= hold_val;
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.check_result(rsp_ch.status, rsp_ch.granted_start, rsp_ch.free_extents);
  end

  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 90);
    req_ch.valid <= 1'b0;
    repeat (gap) @(posedge clk_i);
    burst_left = $urandom_range(0, 12);
  endtask

  task automatic issue(input bit act, input int size, input int start, output status_e st);
    bit [DATA_W-1:0] grant;
    block_t          blk;
    req_ch.valid       <= 1'b1;
    req_ch.action      <= act;
    req_ch.req_size    <= size[DATA_W-1:0];
    req_ch.block_start <= start[DATA_W-1:0];
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    sb.note_request(act, size[DATA_W-1:0], start[DATA_W-1:0], st, grant);
    if (!act && st == ST_OK) begin
      blk.base = grant;
      blk.len  = size[DATA_W-1:0];
      live_q.push_back(blk);
    end
    pace();
  endtask

  // Return a live block, whole or only its upper part.
  task automatic free_live(bit partial);
    int      idx;
    int      cut;
    block_t  blk;
    block_t  keep;
    status_e st;
    idx = $urandom_range(0, live_q.size() - 1);
    blk = live_q[idx];
    live_q.delete(idx);
    if (partial && blk.len > 1) begin
      cut = $urandom_range(1, blk.len - 1);
      issue(1'b1, blk.len - cut, blk.base + cut, st);
      keep.base = blk.base;
      keep.len  = cut;
      if (st == ST_OK) live_q.push_back(keep);
      else             live_q.push_back(blk);
    end else begin
      issue(1'b1, blk.len, blk.base, st);
      if (st != ST_OK) live_q.push_back(blk);
    end
  endtask

  function automatic int pick_size();
    int top;
    top = sb.mem_size;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom_range(1, (top < 8) ? top : 8);
      5, 6, 7:       return $urandom_range(1, (top / 16 > 1) ? top / 16 : 1);
      8:             return $urandom_range(1, top);
      default:       return $urandom_range(0, 65535);
    endcase
  endfunction

  task automatic random_traffic(int count);
    int      r;
    status_e st;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && live_q.size() == 0))
        issue(1'b0, pick_size(), $urandom_range(0, 65534), st);
      else if (r < 85)
        free_live($urandom_range(0, 3) == 0);
      else if (r < 90)
        issue(1'($urandom_range(0, 1)), 0, $urandom_range(0, sb.mem_size), st);
      else if (r < 95)
        issue(1'b1, $urandom_range(1, 16), $urandom_range(0, sb.mem_size - 1), st);
      else
        issue(1'b1, $urandom(), $urandom_range(0, 65534), st);
    end
  endtask

  // Hold the sender until every outstanding result word is back.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(int size);
    drain();
    repeat (10) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size[DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.reload_table(size[DATA_W-1:0]);
    live_q.delete();
  endtask

  // Grab single units, then return every other one, enough to overflow the table.
  task automatic fragment_table();
    status_e st;
    block_t  blk;
    int      n;
    repeat (70) issue(1'b0, 1, 0, st);
    n = live_q.size();
    for (int i = n - 1; i >= 0; i--) begin
      if (live_q[i].base % 2 == 0 && live_q[i].base <= 68) begin
        blk = live_q[i];
        live_q.delete(i);
        issue(1'b1, blk.len, blk.base, st);
        if (st != ST_OK) live_q.push_back(blk);
      end
    end
  endtask

  initial begin
    status_e st;
    int      waited;
    req_ch.valid       = 1'b0;
    req_ch.action      = 1'b0;
    req_ch.req_size    = '0;
    req_ch.block_start = '0;
    rsp_ch.ready       = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    rst_ni             = 1'b0;
    burst_left         = 0;
    steady             = 1'b0;
    hold_left          = 0;
    hold_val           = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero sizes, whole memory, nothing fits, beyond the end
    issue(1'b0, 0, 0, st);
    issue(1'b1, 0, 0, st);
    issue(1'b0, 65535, 65534, st);
    issue(1'b0, 1, 0, st);
    issue(1'b1, 65535, 0, st);
    issue(1'b1, 2, 65534, st);
    issue(1'b1, 1, 65534, st);
    // trims, double free, merges on each side, equal-size tie, exact fit
    issue(1'b0, 100, 0, st);
    issue(1'b0, 200, 0, st);
    issue(1'b0, 300, 0, st);
    issue(1'b0, 50, 0, st);
    issue(1'b1, 100, 0, st);
    issue(1'b1, 100, 400, st);
    issue(1'b1, 10, 450, st);
    issue(1'b0, 100, 0, st);
    issue(1'b0, 60, 0, st);
    issue(1'b1, 100, 0, st);
    issue(1'b1, 100, 300, st);
    issue(1'b1, 60, 400, st);
    issue(1'b1, 100, 500, st);
    issue(1'b1, 50, 600, st);
    issue(1'b1, 200, 100, st);
    issue(1'b0, 65535, 0, st);
    issue(1'b1, 32768, 32767, st);
    live_q.delete();
    random_traffic(90);

    write_size(1);
    issue(1'b0, 1, 0, st);
    issue(1'b0, 1, 0, st);
    issue(1'b1, 1, 0, st);
    issue(1'b1, 1, 0, st);
    issue(1'b1, 1, 1, st);
    live_q.delete();
    random_traffic(20);

    write_size(100);
    fragment_table();
    random_traffic(80);

    write_size($urandom_range(2, 4000));
    random_traffic(120);

    // back-to-back requests, no sender gaps
    steady = 1'b1;
    write_size(65535);
    random_traffic(120);
    steady = 1'b0;

    write_size(300);
    random_traffic(100);

    req_ch.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d result words never arrived", sb.pending()));
    if (sb.fails == 0)
      $display("PASS best_fit_allocator_unit");
    else
      $display("FAIL best_fit_allocator_unit");
    $finish;
  end

endmodule

FILE: best_fit_allocator_unit.f
src/bfa_pkg.sv
src/bfa_req_if.sv
src/bfa_rsp_if.sv
src/bfa_ram.sv
src/best_fit_allocator_unit.sv
dv/best_fit_allocator_unit_test.sv
